// File: rtl/core/atclp_pkg.sv
// ----------------------------------------------------------------------------
// AT command line parser package
// Item types, command codes and character constants shared by the parser.
// ----------------------------------------------------------------------------
package atclp_pkg;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic               is_data;
    logic [7:0]         data_byte;
    logic [1:0]         command_code;
    logic               failed;
    logic signed [31:0] result_value;
    logic               last_of_run;
  } out_item_t;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_REVERSE = 2'd1;
  localparam logic [1:0] CMD_SIZE    = 2'd2;
  localparam logic [1:0] CMD_MULT    = 2'd3;

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Name match flag positions
  localparam int unsigned NM_REVERSE = 0;
  localparam int unsigned NM_SIZE    = 1;
  localparam int unsigned NM_MULT    = 2;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0:    ch = CH_A;
      2'd1:    ch = CH_T;
      2'd2:    ch = CH_PLUS;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] cmd_len(input logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      2'd0:    n = 3'd7;
      2'd1:    n = 3'd4;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Letter p of command word k: REVERSE, SIZE, MULT
  function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [2:0] p);
    logic [55:0] word;
    unique case (k)
      2'd0:    word = {8'h52, 8'h45, 8'h56, 8'h45, 8'h52, 8'h53, 8'h45};
      2'd1:    word = {8'h53, 8'h49, 8'h5A, 8'h45, 24'h000000};
      2'd2:    word = {8'h4D, 8'h55, 8'h4C, 8'h54, 24'h000000};
      default: word = '0;
    endcase
    return word[55 - 8*p -: 8];
  endfunction

endpackage

// File: rtl/core/at_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// AT command line parser
// One input byte per cycle while parsing; once the final byte is taken the
// parser moves to ST_STAT and loads the status item into the output register
// when it has room. A REVERSE line of n string bytes first presents them in
// reverse order, each read from the string store in ST_RD and loaded in ST_WAIT.
// No byte is taken after the final byte until the status item is loaded.
// Synchronous active-low reset clears the parser and output valid.
// ----------------------------------------------------------------------------
module at_command_line_parser_core #(
  parameter int unsigned MAX_LINE   = 64,
  parameter int unsigned MAX_STRING = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  atclp_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output atclp_pkg::out_item_t  out_data
);

  import atclp_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LINE + 1);
  localparam int unsigned SLW = $clog2(MAX_STRING + 1);
  localparam int unsigned AW  = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;

  typedef enum logic [8:0] {
    PH_PREFIX = 9'b000000001,
    PH_NAME   = 9'b000000010,
    PH_ARG    = 9'b000000100,
    PH_STR    = 9'b000001000,
    PH_DONE   = 9'b000010000,
    PH_A0     = 9'b000100000,
    PH_A1     = 9'b001000000,
    PH_B0     = 9'b010000000,
    PH_B1     = 9'b100000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_RD   = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_STAT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [LW-1:0]    pos_r, pos_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic [SLW-1:0]   len_r, len_nxt;
  logic [SLW-1:0]   emit_r, emit_nxt;
  logic [31:0]      first_r, first_nxt;
  logic [31:0]      second_r, second_nxt;
  logic             failed_r, failed_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  logic [7:0]       c;
  logic             digit;
  logic [31:0]      digit_val;
  logic [LW-1:0]    name_pos;
  logic [SLW-1:0]   emit_dec;
  logic [31:0]      product;
  logic             out_free;
  logic             reverse_go;

  assign c         = in_data.line_byte;
  assign digit     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit_val = {28'd0, 4'(c - CH_ZERO)};
  assign name_pos  = pos_r - LW'(3);
  assign emit_dec  = emit_r - SLW'(1);
  assign product   = first_r * second_r;
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_RUN);
  assign ram_re    = (state_r == ST_RD);
  assign ram_raddr = emit_dec[AW-1:0];
  assign ram_waddr = len_r[AW-1:0];

  // Writes happen only while parsing and reads only while emitting, so the
  // two ports never touch the same entry in one cycle.
  atclp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_STRING)
  ) u_string_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    flags_nxt     = flags_r;
    len_nxt       = len_r;
    emit_nxt      = emit_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    reverse_go    = 1'b0;

    unique case (state_r)
      ST_RUN: begin
        if (in_valid) begin
          if (pos_r == LW'(MAX_LINE)) begin
            failed_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + LW'(1);
            if (!failed_r) begin
              unique case (phase_r)
                PH_PREFIX: begin
                  if (pos_r > LW'(2) || c != prefix_char(pos_r[1:0])) begin
                    failed_nxt = 1'b1;
                  end else if (pos_r == LW'(2)) begin
                    phase_nxt = PH_NAME;
                  end
                end
                PH_NAME: begin
                  for (int k = 0; k < 3; k++) begin
                    if (c == CH_EQ) begin
                      if (name_pos != LW'(cmd_len(2'(k)))) begin
                        flags_nxt[k] = 1'b0;
                      end
                    end else if (name_pos >= LW'(cmd_len(2'(k))) ||
                                 c != cmd_char(2'(k), name_pos[2:0])) begin
                      flags_nxt[k] = 1'b0;
                    end
                  end
                  if (c == CH_EQ) begin
                    if (name_pos == '0 || flags_nxt == 3'b000) begin
                      failed_nxt = 1'b1;
                    end else begin
                      phase_nxt = PH_ARG;
                    end
                  end
                end
                PH_ARG: begin
                  if (flags_r[NM_REVERSE] || flags_r[NM_SIZE]) begin
                    if (c == CH_QUOTE) begin
                      phase_nxt = PH_STR;
                    end else begin
                      failed_nxt = 1'b1;
                    end
                  end else if (digit) begin
                    first_nxt = (first_r << 3) + (first_r << 1) + digit_val;
                    phase_nxt = PH_A1;
                  end else begin
                    failed_nxt = 1'b1;
                  end
                end
                PH_STR: begin
                  if (c == CH_QUOTE) begin
                    phase_nxt = PH_DONE;
                  end else if (len_r >= SLW'(MAX_STRING)) begin
                    failed_nxt = 1'b1;
                  end else begin
                    ram_we  = 1'b1;
                    len_nxt = len_r + SLW'(1);
                  end
                end
                PH_DONE: begin
                end
                PH_A0, PH_A1: begin
                  if (digit) begin
                    first_nxt = (first_r << 3) + (first_r << 1) + digit_val;
                    phase_nxt = PH_A1;
                  end else if (c == CH_COMMA && phase_r == PH_A1) begin
                    phase_nxt = PH_B0;
                  end else begin
                    failed_nxt = 1'b1;
                  end
                end
                PH_B0, PH_B1: begin
                  if (digit) begin
                    second_nxt = (second_r << 3) + (second_r << 1) + digit_val;
                    phase_nxt  = PH_B1;
                  end else begin
                    failed_nxt = 1'b1;
                  end
                end
                default: begin
                  failed_nxt = 1'b1;
                end
              endcase
            end
          end
          if (in_data.end_of_line) begin
            reverse_go = !failed_nxt && phase_nxt == PH_DONE &&
                         flags_nxt[NM_REVERSE] && len_nxt != '0;
            emit_nxt   = len_nxt;
            state_nxt  = reverse_go ? ST_RD : ST_STAT;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // hold read data until the output register has room
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.is_data      = 1'b1;
          out_data_nxt.data_byte    = ram_rdata;
          out_data_nxt.command_code = CMD_REVERSE;
          out_data_nxt.failed       = 1'b0;
          out_data_nxt.result_value = '0;
          out_data_nxt.last_of_run  = 1'b0;
          emit_nxt                  = emit_dec;
          state_nxt                 = (emit_r == SLW'(1)) ? ST_STAT : ST_RD;
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.is_data     = 1'b0;
          out_data_nxt.data_byte   = '0;
          out_data_nxt.last_of_run = 1'b1;
          if (failed_r || (phase_r != PH_DONE && phase_r != PH_B1)) begin
            out_data_nxt.command_code = CMD_NONE;
            out_data_nxt.failed       = 1'b1;
            out_data_nxt.result_value = '0;
          end else if (phase_r == PH_B1) begin
            out_data_nxt.command_code = CMD_MULT;
            out_data_nxt.failed       = 1'b0;
            out_data_nxt.result_value = product;
          end else if (flags_r[NM_REVERSE]) begin
            out_data_nxt.command_code = CMD_REVERSE;
            out_data_nxt.failed       = 1'b0;
            out_data_nxt.result_value = '0;
          end else begin
            out_data_nxt.command_code = CMD_SIZE;
            out_data_nxt.failed       = 1'b0;
            out_data_nxt.result_value = 32'(len_r);
          end
          // drop the line and get ready for the next one
          phase_nxt  = PH_PREFIX;
          pos_nxt    = '0;
          flags_nxt  = 3'b111;
          len_nxt    = '0;
          emit_nxt   = '0;
          first_nxt  = '0;
          second_nxt = '0;
          failed_nxt = 1'b0;
          state_nxt  = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      phase_r     <= PH_PREFIX;
      pos_r       <= '0;
      flags_r     <= 3'b111;
      len_r       <= '0;
      emit_r      <= '0;
      first_r     <= '0;
      second_r    <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      flags_r     <= flags_nxt;
      len_r       <= len_nxt;
      emit_r      <= emit_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/atclp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module atclp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: test/tb_at_command_line_parser_core.sv
// ----------------------------------------------------------------------------
// Testbench for the AT command line parser core
// Streams whole command lines into the parser: a directed set covering each
// command, the prefix, name and argument errors and the length limits, then
// random well-formed, corrupted and noise lines. A line-level model predicts
// every result item and a scoreboard checks them in order. Both channels
// idle at random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_at_command_line_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import atclp_pkg::*;

  localparam int unsigned LINE_LIMIT   = 64;
  localparam int unsigned STRING_LIMIT = 32;
  localparam int unsigned ITEM_TARGET  = 370;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef enum logic [3:0] {
    PH_PREFIX, PH_NAME, PH_ARG, PH_STR, PH_DONE, PH_A0, PH_A1, PH_B0, PH_B1
  } parse_phase_t;

  class line_result_board;
    out_item_t    due_results [$];
    int unsigned  mismatches;
    logic [6:0]   line_pos;
    parse_phase_t phase;
    logic [2:0]   name_flags;
    logic [7:0]   str_store [STRING_LIMIT];
    logic [5:0]   str_len;
    logic [31:0]  num_a;
    logic [31:0]  num_b;
    logic         line_bad;
    string        cmd_word [3];
    logic [7:0]   at_word [3];

    function new();
      mismatches = 0;
      cmd_word[NM_REVERSE] = "REVERSE";
      cmd_word[NM_SIZE]    = "SIZE";
      cmd_word[NM_MULT]    = "MULT";
      at_word[0] = CH_A;
      at_word[1] = CH_T;
      at_word[2] = CH_PLUS;
      foreach (str_store[i]) str_store[i] = '0;
      clear_line();
    endfunction

    function void clear_line();
      line_pos   = '0;
      phase      = PH_PREFIX;
      name_flags = 3'b111;
      str_len    = '0;
      num_a      = '0;
      num_b      = '0;
      line_bad   = 1'b0;
    endfunction

    function out_item_t make_item(logic is_d, logic [7:0] b, logic [1:0] code,
                                  logic f, logic [31:0] v, logic last);
      out_item_t it;
      it.is_data      = is_d;
      it.data_byte    = b;
      it.command_code = code;
      it.failed       = f;
      it.result_value = $signed(v);
      it.last_of_run  = last;
      return it;
    endfunction

    function void number_char(logic [7:0] c);
      logic is_digit;
      logic [31:0] d;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d = {24'b0, c - CH_ZERO};
      if (phase == PH_A0 || phase == PH_A1) begin
        if (is_digit) begin
          num_a = num_a * 32'd10 + d;
          phase = PH_A1;
        end else if (c == CH_COMMA && phase == PH_A1) begin
          phase = PH_B0;
        end else begin
          line_bad = 1'b1;
        end
      end else begin
        if (is_digit) begin
          num_b = num_b * 32'd10 + d;
          phase = PH_B1;
        end else begin
          line_bad = 1'b1;
        end
      end
    endfunction

    function void parse_char(logic [7:0] c, int pos);
      int p;
      p = pos - 3;
      case (phase)
        PH_PREFIX: begin
          if (pos > 2 || c != at_word[pos]) line_bad = 1'b1;
          else if (pos == 2) phase = PH_NAME;
        end
        PH_NAME: begin
          if (c == CH_EQ) begin
            for (int k = 0; k < 3; k++)
              if (cmd_word[k].len() != p) name_flags[k] = 1'b0;
            if (p == 0 || name_flags == 3'b000) line_bad = 1'b1;
            else phase = PH_ARG;
          end else begin
            for (int k = 0; k < 3; k++)
              if (p >= cmd_word[k].len() || cmd_word[k][p] != c) name_flags[k] = 1'b0;
          end
        end
        PH_ARG: begin
          if (name_flags[NM_REVERSE] || name_flags[NM_SIZE]) begin
            if (c == CH_QUOTE) phase = PH_STR;
            else line_bad = 1'b1;
          end else begin
            phase = PH_A0;
            number_char(c);
          end
        end
        PH_STR: begin
          if (c == CH_QUOTE) begin
            phase = PH_DONE;
          end else if (str_len >= STRING_LIMIT) begin
            line_bad = 1'b1;
          end else begin
            str_store[str_len] = c;
            str_len++;
          end
        end
        PH_DONE: ;
        default: number_char(c);
      endcase
    endfunction

    // Predict the results of one accepted byte; only the final byte yields any
    function void take_byte(in_item_t it);
      if (line_pos >= LINE_LIMIT) begin
        line_bad = 1'b1;
      end else begin
        if (!line_bad) parse_char(it.line_byte, int'(line_pos));
        line_pos++;
      end
      if (!it.end_of_line) return;
      if (line_bad || (phase != PH_DONE && phase != PH_B1)) begin
        due_results.push_back(make_item(1'b0, 8'h00, CMD_NONE, 1'b1, 32'd0, 1'b1));
      end else if (phase == PH_B1) begin
        due_results.push_back(make_item(1'b0, 8'h00, CMD_MULT, 1'b0, num_a * num_b, 1'b1));
      end else if (name_flags[NM_REVERSE]) begin
        for (int i = int'(str_len) - 1; i >= 0; i--)
          due_results.push_back(make_item(1'b1, str_store[i], CMD_REVERSE, 1'b0, 32'd0, 1'b0));
        due_results.push_back(make_item(1'b0, 8'h00, CMD_REVERSE, 1'b0, 32'd0, 1'b1));
      end else begin
        due_results.push_back(make_item(1'b0, 8'h00, CMD_SIZE, 1'b0, {26'b0, str_len}, 1'b1));
      end
      clear_line();
    endfunction

    function string show(out_item_t it);
      return $sformatf("data=%0b byte=%02h code=%0d failed=%0b value=%0d last=%0b",
                       it.is_data, it.data_byte, it.command_code, it.failed,
                       it.result_value, it.last_of_run);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result item: %s", show(got)));
        return;
      end
      want = due_results.pop_front();
      if (got.is_data != want.is_data || got.data_byte != want.data_byte ||
          got.command_code != want.command_code || got.failed != want.failed ||
          got.result_value != want.result_value || got.last_of_run != want.last_of_run)
        report($sformatf("result mismatch: expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  line_result_board board = new();
  logic [7:0]  line_buf [$];
  int unsigned sent_bytes;
  bit          steady_run;
  bit          hold_req;

  at_command_line_parser_core #(
    .MAX_LINE   (LINE_LIMIT),
    .MAX_STRING (STRING_LIMIT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("tb_at_command_line_parser_core failed");
    $finish;
  end

  // Result side: check each accepted item, hold off once for a long stretch
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_run) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.line_byte   = b;
    it.end_of_line = last;
    // unless steady_run is set, idle while a random draw falls below IDLE_PCT percent
    while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.take_byte(it);
    sent_bytes++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic text_line(input string s);
    put_text(s);
    send_line();
  endtask

  // String content: any byte but the closing quote
  task automatic put_string_bytes(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE) b = b ^ 8'h01;
      line_buf.push_back(b);
    end
  endtask

  task automatic put_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  function automatic int pick_str_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 8);
    if (r < 9) return $urandom_range(9, STRING_LIMIT);
    return $urandom_range(STRING_LIMIT + 1, STRING_LIMIT + 3);
  endfunction

  function automatic int pick_run();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 4);
    return $urandom_range(5, 12);
  endfunction

  task automatic build_valid(input int which);
    case (which)
      0: begin
        put_text("AT+REVERSE=\"");
        put_string_bytes(pick_str_len());
        put_text("\"");
        if ($urandom_range(0, 3) == 0) put_string_bytes($urandom_range(1, 6));
      end
      1: begin
        put_text("AT+SIZE=\"");
        put_string_bytes(pick_str_len());
        put_text("\"");
        if ($urandom_range(0, 3) == 0) put_string_bytes($urandom_range(1, 6));
      end
      default: begin
        put_text("AT+MULT=");
        put_digits(pick_run());
        line_buf.push_back(CH_COMMA);
        put_digits(pick_run());
      end
    endcase
  endtask

  task automatic random_line();
    int kind;
    int pos;
    int target;
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      build_valid($urandom_range(0, 2));
    end else if (kind < 88) begin
      build_valid($urandom_range(0, 2));
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 4))
        0: line_buf[pos] = 8'($urandom_range(0, 255));
        1: line_buf = line_buf[0:pos];
        2: line_buf.insert(pos, 8'($urandom_range(0, 255)));
        3: begin
          // stretch past the line limit
          target = $urandom_range(LINE_LIMIT + 1, LINE_LIMIT + 6);
          while (line_buf.size() < target) put_string_bytes(1);
        end
        default: if (line_buf.size() > 1) line_buf.delete(pos);
      endcase
    end else begin
      if ($urandom_range(0, 1)) put_text("AT+");
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_line();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent_bytes = 0;
    steady_run = 1'b0;
    hold_req   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    text_line("AT+REVERSE=\"hello\"");
    text_line("AT+SIZE=\"abc\"");
    text_line("AT+MULT=12,34");
    // fullest string while the result side holds off
    hold_req = 1'b1;
    put_text("AT+REVERSE=\"");
    put_string_bytes(STRING_LIMIT);
    put_text("\"");
    send_line();
    // byte extremes inside a string
    put_text("AT+REVERSE=\"");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    put_text(",=.\"");
    send_line();
    text_line("AT+MULT=99999999999,7");
    // error and edge-case lines back to back with no idling
    steady_run = 1'b1;
    text_line("BT+SIZE=\"a\"");
    text_line("AT+=\"x\"");
    text_line("AT+FOO=1");
    text_line("AT+SIZE=abc");
    text_line("AT+REVERSE=\"abc");
    text_line("AT+SIZE=\"ab\"x");
    text_line("AT+MULT=1.5,2");
    text_line("AT+MULT=1,2,3");
    text_line("AT+REVERSE=\"\"");
    steady_run = 1'b0;
    text_line("A");
    // one byte over the line limit
    put_text("AT+MULT=1,");
    put_digits(LINE_LIMIT - 9);
    send_line();

    while (sent_bytes < ITEM_TARGET) random_line();
    in_valid <= 1'b0;

    while (board.due_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("tb_at_command_line_parser_core passed");
    end else begin
      $display("tb_at_command_line_parser_core failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/atclp_pkg.sv
rtl/core/atclp_ram.sv
rtl/core/at_command_line_parser_core.sv
test/tb_at_command_line_parser_core.sv
